@@ rtl/core/csvfs_pkg.sv @@
// csvfs_pkg: shared constants and types of the csv field splitter
// used by all rtl/core modules but csvfs_if; no dependencies

package csvfs_pkg;

  localparam int CodeUnitBitsDef = 16;
  localparam int QueueDepthDef   = 4;

  // configuration register indexes
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_SEPARATOR = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_QUOTE     = 1'b1;

  localparam int SeparatorReset = 44;
  localparam int QuoteReset     = 34;
  localparam int SpaceUnit      = 32;

  // what the first result of an item is
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_CHAR = 2'd1,
    KIND_END  = 2'd2
  } first_kind_e;

  // control part of one queue entry
  typedef struct packed {
    first_kind_e first_kind;
    logic        rec_end;
  } entry_ctl_t;

  localparam int EntryCtlW = $bits(entry_ctl_t);

endpackage

@@ rtl/core/csvfs_if.sv @@
// csvfs_in_if / csvfs_out_if: valid/ready channels of the csv field splitter
// no dependencies

interface csvfs_in_if #(
  parameter int CODE_UNIT_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic [CODE_UNIT_BITS-1:0] code_unit;
  logic                      record_last;

  modport source (output valid, output code_unit, output record_last, input ready);
  modport sink   (input valid, input code_unit, input record_last, output ready);
endinterface

interface csvfs_out_if #(
  parameter int CODE_UNIT_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic                      item_kind;
  logic [CODE_UNIT_BITS-1:0] char_value;
  logic                      record_done;
  logic                      run_last;

  modport source (output valid, output item_kind, output char_value,
                  output record_done, output run_last, input ready);
  modport sink   (input valid, input item_kind, input char_value,
                  input record_done, input run_last, output ready);
endinterface

@@ rtl/core/csvfs_front.sv @@
// csvfs_front: config registers and parse state machine, one code unit per cycle
// while the queue has room; depends on csvfs_pkg

module csvfs_front import csvfs_pkg::*; #(
  parameter int CODE_UNIT_BITS = CodeUnitBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CODE_UNIT_BITS-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CODE_UNIT_BITS-1:0] code_unit_i,
  input  logic                      record_last_i,
  input  logic                      q_ready_i,
  output logic                      push_o,
  output entry_ctl_t                push_ctl_o,
  output logic [CODE_UNIT_BITS-1:0] push_char_o
);

  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_PLAIN  = 3'd1;
  localparam logic [2:0] MODE_QUOTED = 3'd2;
  localparam logic [2:0] MODE_QSEEN  = 3'd3;
  localparam logic [2:0] MODE_TAIL   = 3'd4;

  logic [CODE_UNIT_BITS-1:0] sep_q, quote_q;
  logic [2:0]                mode_q, mode_d;
  logic                      accept, is_sep, is_quote, is_space;
  first_kind_e               first_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= CODE_UNIT_BITS'(SeparatorReset);
      quote_q <= CODE_UNIT_BITS'(QuoteReset);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SEPARATOR: sep_q   <= cfg_wdata_i;
        CFG_QUOTE:     quote_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign is_sep     = (code_unit_i == sep_q);
  assign is_quote   = (quote_q != '0) && (code_unit_i == quote_q);
  assign is_space   = (code_unit_i == CODE_UNIT_BITS'(SpaceUnit));

  always_comb begin
    mode_d     = mode_q;
    first_kind = KIND_NONE;
    case (mode_q)
      MODE_PLAIN: begin
        if (is_sep) begin
          first_kind = KIND_END;
          mode_d     = MODE_START;
        end else begin
          first_kind = KIND_CHAR;
        end
      end
      MODE_QUOTED: begin
        if (is_quote) mode_d = MODE_QSEEN;
        else          first_kind = KIND_CHAR;
      end
      MODE_QSEEN: begin
        if (is_quote) begin
          first_kind = KIND_CHAR;
          mode_d     = MODE_QUOTED;
        end else if (is_sep) begin
          first_kind = KIND_END;
          mode_d     = MODE_START;
        end else begin
          mode_d = MODE_TAIL;
        end
      end
      MODE_TAIL: begin
        if (is_sep) begin
          first_kind = KIND_END;
          mode_d     = MODE_START;
        end
      end
      default: begin
        // field start, also covers unused codes
        if (is_space) begin
          mode_d = MODE_START;
        end else if (is_quote) begin
          // quote equal to separator opens a plain field
          mode_d = (quote_q == sep_q) ? MODE_PLAIN : MODE_QUOTED;
        end else if (is_sep) begin
          first_kind = KIND_END;
          mode_d     = MODE_START;
        end else begin
          first_kind = KIND_CHAR;
          mode_d     = MODE_PLAIN;
        end
      end
    endcase
    if (record_last_i) mode_d = MODE_START;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_START;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  // items that cause no result never enter the queue
  assign push_o                = accept && ((first_kind != KIND_NONE) || record_last_i);
  assign push_ctl_o.first_kind = first_kind;
  assign push_ctl_o.rec_end    = record_last_i;
  assign push_char_o           = code_unit_i;

  a_last_resets_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && record_last_i |=> mode_q == MODE_START)
    else $error("mode not back at field start after record end");

  a_field_end_resets_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (first_kind == KIND_END) |=> mode_q == MODE_START)
    else $error("mode not at field start after field end");

  a_push_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && !record_last_i |-> first_kind != KIND_NONE)
    else $error("queue entry without any result");

endmodule

@@ rtl/core/csvfs_queue.sv @@
// csvfs_queue: small fifo of decoded items between front and back
// depends on csvfs_pkg

module csvfs_queue import csvfs_pkg::*; #(
  parameter int WIDTH = EntryCtlW + CodeUnitBitsDef,
  parameter int DEPTH = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign ready_o = (count_q != CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (do_pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a transfer in");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count missed a transfer out");

endmodule

@@ rtl/core/csvfs_back.sv @@
// csvfs_back: expands queue entries into result items behind an output register
// depends on csvfs_pkg

module csvfs_back import csvfs_pkg::*; #(
  parameter int CODE_UNIT_BITS = CodeUnitBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  entry_ctl_t                head_ctl_i,
  input  logic [CODE_UNIT_BITS-1:0] head_char_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      item_kind_o,
  output logic [CODE_UNIT_BITS-1:0] char_value_o,
  output logic                      record_done_o,
  output logic                      run_last_o
);

  // phase set: first result of the head entry is out, record end still owed
  logic                      phase_q, phase_d;
  logic                      out_valid_q;
  logic                      kind_q, kind_d;
  logic [CODE_UNIT_BITS-1:0] char_q, char_d;
  logic                      done_q, done_d;
  logic                      last_q, last_d;
  logic                      load, emit_done;

  assign load      = head_valid_i && (!out_valid_q || out_ready_i);
  assign emit_done = phase_q || (head_ctl_i.first_kind == KIND_NONE);

  always_comb begin
    if (emit_done) begin
      kind_d  = 1'b1;
      char_d  = '0;
      done_d  = 1'b1;
      last_d  = 1'b1;
      pop_o   = load;
      phase_d = 1'b0;
    end else begin
      kind_d  = (head_ctl_i.first_kind == KIND_END);
      char_d  = (head_ctl_i.first_kind == KIND_CHAR) ? head_char_i : '0;
      done_d  = 1'b0;
      last_d  = !head_ctl_i.rec_end;
      pop_o   = load && !head_ctl_i.rec_end;
      phase_d = head_ctl_i.rec_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        phase_q     <= phase_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= kind_d;
      char_q <= char_d;
      done_q <= done_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign item_kind_o   = kind_q;
  assign char_value_o  = char_q;
  assign record_done_o = done_q;
  assign run_last_o    = last_q;

  a_phase_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> head_valid_i && head_ctl_i.rec_end)
    else $error("record end owed with no matching queue head");

  a_partial_run_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !last_q |-> phase_q)
    else $error("non-final result out but no record end pending");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> last_q && kind_q)
    else $error("record end result not marked as end of run");

endmodule

@@ rtl/core/csv_field_splitter.sv @@
// csv_field_splitter: one code unit per transfer in, field characters and
// field ends out. The front takes a code unit every cycle while its queue
// (QUEUE_DEPTH entries) has room; the back drives one result per cycle when
// out_o.ready is high. A unit that ends a record after a character or field
// end yields two results; one that yields nothing never enters the queue.
// Configuration writes go to index 0 (separator) and 1 (quote, zero turns
// quoting off), only while idle: a user rule that the block does not enforce.
// depends on csvfs_pkg, csvfs_if, csvfs_front, csvfs_queue, csvfs_back

module csv_field_splitter import csvfs_pkg::*; #(
  parameter int CODE_UNIT_BITS = CodeUnitBitsDef,
  parameter int QUEUE_DEPTH    = QueueDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CODE_UNIT_BITS-1:0] cfg_wdata_i,
  csvfs_in_if.sink                  in_i,
  csvfs_out_if.source               out_o
);

  localparam int EntryW = EntryCtlW + CODE_UNIT_BITS;

  logic                      push, q_ready, q_valid, pop;
  entry_ctl_t                push_ctl, head_ctl;
  logic [CODE_UNIT_BITS-1:0] push_char, head_char;
  logic [EntryW-1:0]         head_data;

  csvfs_front #(
    .CODE_UNIT_BITS(CODE_UNIT_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_i.ready),
    .code_unit_i   (in_i.code_unit),
    .record_last_i (in_i.record_last),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .push_ctl_o    (push_ctl),
    .push_char_o   (push_char)
  );

  csvfs_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_ctl, push_char}),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_data)
  );

  assign head_ctl  = entry_ctl_t'(head_data[EntryW-1 -: EntryCtlW]);
  assign head_char = head_data[CODE_UNIT_BITS-1:0];

  csvfs_back #(
    .CODE_UNIT_BITS(CODE_UNIT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_ctl_i    (head_ctl),
    .head_char_i   (head_char),
    .pop_o         (pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .item_kind_o   (out_o.item_kind),
    .char_value_o  (out_o.char_value),
    .record_done_o (out_o.record_done),
    .run_last_o    (out_o.run_last)
  );

endmodule

@@ tb/sv/tb_csv_field_splitter.sv @@
// tb_csv_field_splitter: self-checking testbench of the csv field splitter,
// a directed table followed by random records under several separator/quote settings
// depends on csvfs_pkg, csvfs_in_if, csvfs_out_if and csv_field_splitter

module tb_csv_field_splitter;
  import csvfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int UnitW        = 16;
  localparam int DrainCycles  = 12;
  localparam int HoldCycles   = 300;
  localparam int CycleLimit   = 600000;
  localparam int PhaseUnits   = 250;
  localparam int MaxReported  = 10;

  localparam logic ITEM_CHAR = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  typedef enum logic [2:0] {
    PM_START  = 3'd0,
    PM_PLAIN  = 3'd1,
    PM_QUOTED = 3'd2,
    PM_QSEEN  = 3'd3,
    PM_TAIL   = 3'd4
  } parse_mode_e;

  typedef enum logic [1:0] {
    RX_FREE      = 2'd0,
    RX_MOSTLY_ON = 2'd1,
    RX_MOSTLY_OFF = 2'd2,
    RX_TOGGLE    = 2'd3
  } rx_style_e;

  typedef enum logic {
    ROW_UNIT = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    logic             item_kind;
    logic [UnitW-1:0] char_value;
    logic             record_done;
    logic             run_last;
  } split_res_t;

  typedef struct packed {
    row_kind_e        kind;
    logic [UnitW-1:0] a;      // code unit, or separator for a register row
    logic [UnitW-1:0] b;      // quote for a register row
    logic             last;
    logic             typed;
    logic [1:0]       n_exp;
    split_res_t       e0;
    split_res_t       e1;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [UnitW-1:0]   cfg_wdata;

  csvfs_in_if  #(.CODE_UNIT_BITS(UnitW)) in_ch ();
  csvfs_out_if #(.CODE_UNIT_BITS(UnitW)) out_ch ();

  csv_field_splitter #(.CODE_UNIT_BITS(UnitW)) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // predictor state
  parse_mode_e      pmode;
  logic [UnitW-1:0] sep_cfg;
  logic [UnitW-1:0] quote_cfg;
  split_res_t       field_q[$];

  // typed expectation travelling with the unit on the input channel
  logic       row_typed;
  logic [1:0] row_n;
  split_res_t row_e0, row_e1;

  int  mismatch_count;
  int  units_sent;
  int  results_seen;
  int  records_sent;
  int  settings_used;
  int  cycle_count;
  int  burst_left;
  int  rx_cycle;
  int  holdoff_left;
  logic holdoff_req;
  rx_style_e rx_style;

  always #1ns clk = ~clk;

  function automatic split_res_t mk_char(input logic [UnitW-1:0] c, input logic rl);
    mk_char = '{item_kind: ITEM_CHAR, char_value: c, record_done: 1'b0, run_last: rl};
  endfunction

  function automatic split_res_t mk_end(input logic done, input logic rl);
    mk_end = '{item_kind: ITEM_END, char_value: '0, record_done: done, run_last: rl};
  endfunction

  function automatic void add_unit(ref logic [UnitW-1:0] q[$], input logic [UnitW-1:0] u);
    q.insert(q.size(), u);
  endfunction

  function automatic void add_row(ref dir_row_t rows[$], input dir_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // next mode and results for one code unit
  function automatic int split_unit(input logic [UnitW-1:0] cu, input logic last,
                                    output split_res_t r0, output split_res_t r1);
    split_res_t res [2];
    int n;
    logic is_sep;
    logic is_quote;
    n = 0;
    res[0] = '0;
    res[1] = '0;
    is_sep = (cu == sep_cfg);
    is_quote = (quote_cfg != '0) && (cu == quote_cfg);
    case (pmode)
      PM_PLAIN: begin
        if (is_sep) begin
          res[n] = mk_end(1'b0, 1'b0); n++;
          pmode = PM_START;
        end else begin
          res[n] = mk_char(cu, 1'b0); n++;
        end
      end
      PM_QUOTED: begin
        if (is_quote) pmode = PM_QSEEN;
        else begin
          res[n] = mk_char(cu, 1'b0); n++;
        end
      end
      PM_QSEEN: begin
        if (is_quote) begin
          res[n] = mk_char(cu, 1'b0); n++;
          pmode = PM_QUOTED;
        end else if (is_sep) begin
          res[n] = mk_end(1'b0, 1'b0); n++;
          pmode = PM_START;
        end else begin
          pmode = PM_TAIL;
        end
      end
      PM_TAIL: begin
        if (is_sep) begin
          res[n] = mk_end(1'b0, 1'b0); n++;
          pmode = PM_START;
        end
      end
      default: begin
        // a space is skipped first, even when it is the separator or the quote
        if (cu == UnitW'(SpaceUnit)) pmode = PM_START;
        else if (is_quote) pmode = (quote_cfg == sep_cfg) ? PM_PLAIN : PM_QUOTED;
        else if (is_sep) begin
          res[n] = mk_end(1'b0, 1'b0); n++;
          pmode = PM_START;
        end else begin
          res[n] = mk_char(cu, 1'b0); n++;
          pmode = PM_PLAIN;
        end
      end
    endcase
    if (last) begin
      res[n] = mk_end(1'b1, 1'b0); n++;
      pmode = PM_START;
    end
    if (n > 0) res[n-1].run_last = 1'b1;
    r0 = res[0];
    r1 = res[1];
    return n;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MaxReported) $display("[%0t] MISMATCH: %s", $realtime, what);
  endfunction

  // prediction on input transfers, comparison on output transfers
  always @(posedge clk) begin : field_check
    int n;
    split_res_t r0, r1, got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        n = split_unit(in_ch.code_unit, in_ch.record_last, r0, r1);
        if (row_typed) begin
          n = row_n;
          r0 = row_e0;
          r1 = row_e1;
        end
        if (n > 0) field_q.insert(field_q.size(), r0);
        if (n > 1) field_q.insert(field_q.size(), r1);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got = '{item_kind: out_ch.item_kind, char_value: out_ch.char_value,
                record_done: out_ch.record_done, run_last: out_ch.run_last};
        if (field_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind=%0b char=%h done=%0b run_last=%0b",
                                  got.item_kind, got.char_value, got.record_done,
                                  got.run_last));
        end else begin
          want = field_q.pop_front();
          if (got.item_kind !== want.item_kind || got.char_value !== want.char_value ||
              got.record_done !== want.record_done || got.run_last !== want.run_last)
            note_mismatch($sformatf(
              "exp kind=%0b char=%h done=%0b run_last=%0b, got kind=%0b char=%h done=%0b run_last=%0b",
              want.item_kind, want.char_value, want.record_done, want.run_last,
              got.item_kind, got.char_value, got.record_done, got.run_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, field_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  always @(negedge clk) begin
    rx_cycle++;
    if (holdoff_req && holdoff_left == 0) begin
      holdoff_left = HoldCycles;
      holdoff_req = 1'b0;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_cycle % 97 == 0) rx_style = rx_style_e'(2'($urandom_range(0, 3)));
      case (rx_style)
        RX_FREE:       out_ch.ready <= 1'b1;
        RX_MOSTLY_ON:  out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_MOSTLY_OFF: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:       out_ch.ready <= rx_cycle[0];
      endcase
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_unit(input logic [UnitW-1:0] cu, input logic last, input logic typed,
                           input logic [1:0] n_exp, input split_res_t e0,
                           input split_res_t e1);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.code_unit = cu;
    in_ch.record_last = last;
    row_typed = typed;
    row_n = n_exp;
    row_e0 = e0;
    row_e1 = e1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    units_sent++;
    @(negedge clk);
  endtask

  // wait until no result is still expected, then allow extra cycles
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    row_typed = 1'b0;
    while (field_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic set_regs(input logic [UnitW-1:0] sep, input logic [UnitW-1:0] quote);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = CFG_SEPARATOR;
    cfg_wdata = sep;
    @(negedge clk);
    cfg_index = CFG_QUOTE;
    cfg_wdata = quote;
    @(negedge clk);
    cfg_we = 1'b0;
    sep_cfg = sep;
    quote_cfg = quote;
    settings_used++;
  endtask

  function automatic logic [UnitW-1:0] pick_char();
    case ($urandom_range(0, 15))
      11: return UnitW'($urandom_range(0, 65535));
      12: return '1;
      13: return '0;
      14: return UnitW'(SpaceUnit);
      15: return sep_cfg;
      default: return UnitW'("a") + UnitW'($urandom_range(0, 25));
    endcase
  endfunction

  // one record of mostly well-formed fields with random content and some noise
  task automatic send_record();
    logic [UnitW-1:0] rec_q[$];
    int nf;
    int style;
    rec_q = {};
    nf = $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 2)) add_unit(rec_q, UnitW'(SpaceUnit));
      style = $urandom_range(0, 9);
      if (style < 5) begin
        repeat ($urandom_range(0, 5)) add_unit(rec_q, pick_char());
      end else if (style < 8) begin
        add_unit(rec_q, quote_cfg);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 5) == 0) begin
            add_unit(rec_q, quote_cfg);
            add_unit(rec_q, quote_cfg);
          end else begin
            add_unit(rec_q, pick_char());
          end
        end
        // now and then the quote is left open
        if ($urandom_range(0, 7) != 0) add_unit(rec_q, quote_cfg);
        if ($urandom_range(0, 2) == 0)
          repeat ($urandom_range(1, 2)) add_unit(rec_q, pick_char());
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: add_unit(rec_q, sep_cfg);
            1: add_unit(rec_q, quote_cfg);
            2: add_unit(rec_q, UnitW'(SpaceUnit));
            default: add_unit(rec_q, UnitW'($urandom_range(0, 65535)));
          endcase
        end
      end
      if (f < nf - 1 || $urandom_range(0, 4) == 0) add_unit(rec_q, sep_cfg);
    end
    if (rec_q.size() == 0) add_unit(rec_q, pick_char());
    foreach (rec_q[i])
      send_unit(rec_q[i], i == rec_q.size() - 1, 1'b0, 2'd0, '0, '0);
    records_sent++;
  endtask

  initial begin
    dir_row_t dir_rows[$];
    logic [UnitW-1:0] sep_set [8];
    logic [UnitW-1:0] quote_set [8];
    int phase_start;
    logic holdoff_done;

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SEPARATOR;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.code_unit = '0;
    in_ch.record_last = 1'b0;
    out_ch.ready = 1'b0;
    row_typed = 1'b0;
    row_n = '0;
    row_e0 = '0;
    row_e1 = '0;
    holdoff_req = 1'b0;
    holdoff_left = 0;
    holdoff_done = 1'b0;
    rx_style = RX_FREE;
    burst_left = 0;
    pmode = PM_START;
    sep_cfg = UnitW'(SeparatorReset);
    quote_cfg = UnitW'(QuoteReset);

    // directed table: unit, record end, and the results where they are obvious
    add_row(dir_rows, '{ROW_UNIT, "a", '0, 1'b0, 1'b1, 2'd1, mk_char("a", 1'b1), '0});
    add_row(dir_rows, '{ROW_UNIT, ",", '0, 1'b0, 1'b1, 2'd1, mk_end(1'b0, 1'b1), '0});
    add_row(dir_rows, '{ROW_UNIT, " ", '0, 1'b0, 1'b1, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "\"", '0, 1'b0, 1'b1, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "\"", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "\"", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "x", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "\"", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "z", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, ",", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, '1, '0, 1'b1, 1'b1, 2'd2,
                        mk_char('1, 1'b0), mk_end(1'b1, 1'b1)});
    add_row(dir_rows, '{ROW_UNIT, ",", '0, 1'b1, 1'b1, 2'd2,
                        mk_end(1'b0, 1'b0), mk_end(1'b1, 1'b1)});
    // quoting off, separator zero
    add_row(dir_rows, '{ROW_CFG, '0, '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, '0, '0, 1'b0, 1'b1, 2'd1, mk_end(1'b0, 1'b1), '0});
    add_row(dir_rows, '{ROW_UNIT, "\"", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, '0, '0, 1'b1, 1'b0, 2'd0, '0, '0});
    // quote equal to separator
    add_row(dir_rows, '{ROW_CFG, '1, '1, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, '1, '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "b", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, '1, '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, " ", '0, 1'b1, 1'b1, 2'd1, mk_end(1'b1, 1'b1), '0});
    // space as separator and quote at once
    add_row(dir_rows, '{ROW_CFG, " ", " ", 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, " ", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "q", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, " ", '0, 1'b1, 1'b0, 2'd0, '0, '0});
    // quote left open to the record end
    add_row(dir_rows, '{ROW_CFG, UnitW'(SeparatorReset), UnitW'(QuoteReset),
                        1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "\"", '0, 1'b0, 1'b0, 2'd0, '0, '0});
    add_row(dir_rows, '{ROW_UNIT, "k", '0, 1'b1, 1'b0, 2'd0, '0, '0});

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_regs(dir_rows[i].a, dir_rows[i].b);
      else
        send_unit(dir_rows[i].a, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].n_exp,
                  dir_rows[i].e0, dir_rows[i].e1);
    end

    sep_set   = '{UnitW'(SeparatorReset), ";", UnitW'(SeparatorReset), '1, '0, "|",
                  UnitW'($urandom_range(0, 65535)), 16'h0009};
    quote_set = '{UnitW'(QuoteReset), "'", '0, '0, '1, "|",
                  UnitW'($urandom_range(0, 65535)), "\""};

    for (int ph = 0; ph < 8; ph++) begin
      set_regs(sep_set[ph], quote_set[ph]);
      phase_start = units_sent;
      while (units_sent - phase_start < PhaseUnits) begin
        // one long receiver hold-off while records keep coming
        if (ph == 1 && !holdoff_done && units_sent - phase_start > 60) begin
          holdoff_req = 1'b1;
          holdoff_done = 1'b1;
        end
        send_record();
      end
    end

    wait_drained();
    $display("sent %0d code units in %0d random records plus directed rows, %0d settings",
             units_sent, records_sent, settings_used);
    $display("checked %0d results, %0d mismatches", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
